>>> src/circular_list_engine_assert.svh
// Assertion macros used by the checker file of the list engine.
`ifndef CIRCULAR_LIST_ENGINE_ASSERT_SVH
`define CIRCULAR_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list engine check failed");

`endif

>>> src/cle_pkg.sv
// Package with the types and constants of the circular list engine.
`default_nettype none

package cle_pkg;

  localparam int CLE_CAPACITY = 16;
  localparam int VAL_W = 32;

  // Request kinds as carried on the input word.
  typedef enum logic [2:0] {
    K_INS_HEAD  = 3'd0,
    K_INS_TAIL  = 3'd1,
    K_INS_AFTER = 3'd2,
    K_DEL_HEAD  = 3'd3,
    K_DEL_TAIL  = 3'd4,
    K_DEL_KEY   = 3'd5,
    K_SEARCH    = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Which cell the scan token stops at.
  typedef enum logic [2:0] {
    MM_NONE,
    MM_KEY,
    MM_HEAD,
    MM_TAIL,
    MM_END
  } match_t;

  // How the cells move their values when an update is applied.
  typedef enum logic [1:0] {
    UP_NONE,
    UP_INS_BEFORE,
    UP_INS_AFTER,
    UP_DEL
  } upd_t;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [VAL_W-1:0] value;
  } tok_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic             clr;
    match_t           mode;
    upd_t             op;
    logic [VAL_W-1:0] key;
    logic [VAL_W-1:0] data;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> src/cle_if.sv
// Valid/ready channel interfaces for the request and result words.
`default_nettype none

interface cle_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic signed [31:0] data;
  logic signed [31:0] key;

  modport source (output valid, output kind, output data, output key, input ready);
  modport sink (input valid, input kind, input data, input key, output ready);
endinterface

interface cle_out_if #(parameter int CNT_W = 5);
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              found;
  logic signed [31:0] removed_value;
  logic [CNT_W-1:0]  count;

  modport source (output valid, output status, output found, output removed_value,
                  output count, input ready);
  modport sink (input valid, input status, input found, input removed_value,
                input count, output ready);
endinterface

`default_nettype wire

>>> src/cle_cell.sv
// One list cell: holds one entry, checks the passing scan token and shifts on update.
`default_nettype none

module cle_cell
  import cle_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_ctl_t        ctl,
  input  wire logic [CNT_W-1:0] count,
  input  wire tok_t             tok_in,
  output tok_t                  tok_out,
  input  wire logic [VAL_W-1:0] left_val,
  input  wire logic             left_at,
  input  wire logic [VAL_W-1:0] right_val,
  output logic [VAL_W-1:0]      val,
  output logic                  at
);

  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX1_C = CNT_W'(IDX + 1);

  logic [VAL_W-1:0] val_r, val_nxt;
  logic             at_r, at_nxt;
  logic             past_r, past_nxt;
  tok_t             tok_r, tok_nxt;
  logic             in_range;
  logic             match;
  logic             hit;

  assign in_range = IDX_C < count;

  // The head cell is the target of head requests even on an empty list, so
  // that an insert at the head lands in cell 0.
  always_comb begin
    case (ctl.mode)
      MM_KEY:  match = in_range && (val_r == ctl.key);
      MM_HEAD: match = (IDX == 0);
      MM_TAIL: match = (count == IDX1_C);
      MM_END:  match = (count == IDX_C);
      default: match = 1'b0;
    endcase
  end

  assign hit = tok_in.valid && !tok_in.found && match;

  always_comb begin
    tok_nxt.valid = tok_in.valid;
    tok_nxt.found = tok_in.found | hit;
    tok_nxt.value = hit ? val_r : tok_in.value;

    if (ctl.clr) begin
      at_nxt   = 1'b0;
      past_nxt = 1'b0;
    end else begin
      at_nxt   = at_r | hit;
      past_nxt = past_r | (tok_in.valid && tok_in.found);
    end

    val_nxt = val_r;
    case (ctl.op)
      UP_INS_BEFORE: begin
        if (at_r) val_nxt = ctl.data;
        else if (past_r) val_nxt = left_val;
      end
      UP_INS_AFTER: begin
        if (past_r && left_at) val_nxt = ctl.data;
        else if (past_r) val_nxt = left_val;
      end
      UP_DEL: begin
        if (at_r || past_r) val_nxt = right_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
      tok_r.found <= 1'b0;
      at_r        <= 1'b0;
      past_r      <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
      tok_r.found <= tok_nxt.found;
      at_r        <= at_nxt;
      past_r      <= past_nxt;
    end
    tok_r.value <= tok_nxt.value;
    val_r       <= val_nxt;
  end

  assign tok_out = tok_r;
  assign val     = val_r;
  assign at      = at_r;

endmodule

`default_nettype wire

>>> src/cle_ctrl.sv
// Request sequencer: launches the scan, decides the result and drives the output word.
`default_nettype none

module cle_ctrl
  import cle_pkg::*;
#(
  parameter int CAPACITY = CLE_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       in_kind,
  input  wire logic [VAL_W-1:0] in_data,
  input  wire logic [VAL_W-1:0] in_key,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_status,
  output logic                  out_found,
  output logic [VAL_W-1:0]      out_removed_value,
  output logic [CNT_W-1:0]      out_count,
  output cell_ctl_t             ctl,
  output logic [CNT_W-1:0]      count,
  output tok_t                  launch,
  input  wire tok_t             tok_end
);

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  typedef enum logic [1:0] {IDLE, SCAN, FIN} state_t;

  state_t           state_r;
  kind_t            kind_r;
  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] key_r;
  logic             launch_r;
  logic [CNT_W-1:0] cnt_r;
  status_t          res_status_r;
  logic             res_found_r;
  logic [VAL_W-1:0] res_rem_r;
  logic             res_do_r;
  logic [CNT_W-1:0] res_cnt_r;
  logic             ov_r;
  logic [1:0]       os_r;
  logic             of_r;
  logic [VAL_W-1:0] orm_r;
  logic [CNT_W-1:0] oc_r;

  status_t          d_status;
  logic             d_found;
  logic [VAL_W-1:0] d_rem;
  logic             d_do;
  logic [CNT_W-1:0] d_cnt;
  match_t           mode;
  upd_t             upd;
  logic             accept;
  logic             free;
  logic             full;
  logic             empty;

  assign in_ready = (state_r == IDLE);
  assign accept   = in_valid && in_ready;
  assign free     = !ov_r || out_ready;
  assign full     = (cnt_r == CAP_C);
  assign empty    = (cnt_r == '0);

  // Scan target and cell update for each request kind.
  always_comb begin
    unique case (kind_r) inside
      K_INS_HEAD:                   begin mode = MM_HEAD; upd = UP_INS_BEFORE; end
      K_INS_TAIL:                   begin mode = MM_END;  upd = UP_INS_BEFORE; end
      K_INS_AFTER:                  begin mode = MM_KEY;  upd = UP_INS_AFTER;  end
      K_DEL_HEAD:                   begin mode = MM_HEAD; upd = UP_DEL;        end
      K_DEL_TAIL:                   begin mode = MM_TAIL; upd = UP_DEL;        end
      K_DEL_KEY:                    begin mode = MM_KEY;  upd = UP_DEL;        end
      K_SEARCH:                     begin mode = MM_KEY;  upd = UP_NONE;       end
      default:                      begin mode = MM_NONE; upd = UP_NONE;       end
    endcase
  end

  // Result once the token has left the last cell.
  always_comb begin
    d_status = ST_OK;
    d_found  = 1'b0;
    d_rem    = '0;
    d_do     = 1'b0;
    d_cnt    = cnt_r;
    unique case (kind_r) inside
      K_INS_HEAD, K_INS_TAIL: begin
        if (full) begin
          d_status = ST_FULL;
        end else begin
          d_do  = 1'b1;
          d_cnt = cnt_r + ONE_C;
        end
      end
      K_INS_AFTER: begin
        if (empty) begin
          d_status = ST_EMPTY;
        end else if (!tok_end.found) begin
          d_status = ST_NOTFOUND;
        end else begin
          d_found = 1'b1;
          if (full) begin
            d_status = ST_FULL;
          end else begin
            d_do  = 1'b1;
            d_cnt = cnt_r + ONE_C;
          end
        end
      end
      K_DEL_HEAD, K_DEL_TAIL: begin
        if (empty) begin
          d_status = ST_EMPTY;
        end else begin
          d_do  = 1'b1;
          d_rem = tok_end.value;
          d_cnt = cnt_r - ONE_C;
        end
      end
      K_DEL_KEY, K_SEARCH: begin
        if (empty) begin
          d_status = ST_EMPTY;
        end else if (!tok_end.found) begin
          d_status = ST_NOTFOUND;
        end else begin
          d_found = 1'b1;
          if (kind_r == K_DEL_KEY) begin
            d_do  = 1'b1;
            d_rem = tok_end.value;
            d_cnt = cnt_r - ONE_C;
          end
        end
      end
      default: d_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= IDLE;
      launch_r <= 1'b0;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      launch_r <= accept;
      // A new result word takes the output register as the old one leaves.
      if (state_r == FIN && free) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      unique case (state_r)
        IDLE: begin
          if (in_valid) begin
            kind_r  <= kind_t'(in_kind);
            data_r  <= in_data;
            key_r   <= in_key;
            state_r <= SCAN;
          end
        end
        SCAN: begin
          if (tok_end.valid) begin
            res_status_r <= d_status;
            res_found_r  <= d_found;
            res_rem_r    <= d_rem;
            res_do_r     <= d_do;
            res_cnt_r    <= d_cnt;
            state_r      <= FIN;
          end
        end
        FIN: begin
          if (free) begin
            os_r    <= res_status_r;
            of_r    <= res_found_r;
            orm_r   <= res_rem_r;
            oc_r    <= res_cnt_r;
            cnt_r   <= res_cnt_r;
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign ctl.clr  = accept;
  assign ctl.mode = mode;
  assign ctl.op   = (state_r == FIN && free && res_do_r) ? upd : UP_NONE;
  assign ctl.key  = key_r;
  assign ctl.data = data_r;

  assign count        = cnt_r;
  assign launch.valid = launch_r;
  assign launch.found = 1'b0;
  assign launch.value = '0;

  assign out_valid         = ov_r;
  assign out_status        = os_r;
  assign out_found         = of_r;
  assign out_removed_value = orm_r;
  assign out_count         = oc_r;

endmodule

`default_nettype wire

>>> src/circular_list_engine.sv
// Top level of the circular list engine: sequencer plus a row of list cells.
// Requests are taken one at a time: the scan token walks the whole cell row,
// one cell per cycle, before the update is applied and the next request is taken.
// A waiting result word holds the update and so also blocks the next request.
// Reset (rst_n low, synchronous) empties the list; stored values are not cleared.
`default_nettype none

module circular_list_engine
  import cle_pkg::*;
#(
  parameter int CAPACITY = CLE_CAPACITY
) (
  input wire logic  clk,
  input wire logic  rst_n,
  cle_in_if.sink    in_ch,
  cle_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Every request runs the same way. The sequencer takes the request word,
  // clears the per-cell marks and launches a token into cell 0. The token
  // moves one cell per cycle toward the tail. The first cell that matches
  // the request (a key match, the head, the tail, or the first free slot)
  // marks itself, loads its value into the token and flags it found; all
  // cells the found token passes afterward mark themselves as lying past
  // the hit. When the token leaves the last cell, the sequencer knows
  // whether the request succeeds and what it removes.
  //
  // In the following cycle, once the output register is free, the update
  // is broadcast: on insert the marked cells take the new value or the
  // value of their left neighbor, on delete they take the value of their
  // right neighbor. The count moves in the same cycle as the result word
  // is loaded. Cells above the count hold stale values that are never read.

  cell_ctl_t        ctl;
  logic [CNT_W-1:0] count;
  tok_t             launch;
  tok_t             tok_w [CAPACITY];
  logic [VAL_W-1:0] val_w [CAPACITY];
  logic             at_w  [CAPACITY];

  cle_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_kind           (in_ch.kind),
    .in_data           (in_ch.data),
    .in_key            (in_ch.key),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_found         (out_ch.found),
    .out_removed_value (out_ch.removed_value),
    .out_count         (out_ch.count),
    .ctl               (ctl),
    .count             (count),
    .launch            (launch),
    .tok_end           (tok_w[CAPACITY-1])
  );

  // The cell row. The head cell sees no left neighbor and the tail cell
  // no right neighbor; those inputs are tied off, and the head's are never selected.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    tok_t             tok_in;
    logic [VAL_W-1:0] left_val;
    logic             left_at;
    logic [VAL_W-1:0] right_val;

    if (i == 0) begin : g_head
      assign tok_in   = launch;
      assign left_val = '0;
      assign left_at  = 1'b0;
    end else begin : g_mid
      assign tok_in   = tok_w[i-1];
      assign left_val = val_w[i-1];
      assign left_at  = at_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_notail
      assign right_val = val_w[i+1];
    end

    cle_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .count     (count),
      .tok_in    (tok_in),
      .tok_out   (tok_w[i]),
      .left_val  (left_val),
      .left_at   (left_at),
      .right_val (right_val),
      .val       (val_w[i]),
      .at        (at_w[i])
    );
  end

endmodule

`default_nettype wire

>>> src/cle_checker.sv
// Port-level checker for the circular list engine and its bind to the top level.
`default_nettype none

`include "circular_list_engine_assert.svh"

module cle_checker
  import cle_pkg::*;
#(
  parameter int CAPACITY = CLE_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [1:0]       out_status,
  input wire logic             out_found,
  input wire logic [31:0]      out_removed_value,
  input wire logic [CNT_W-1:0] out_count
);

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  // A stalled result word keeps its contents.
  `CLE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_status, out_found, out_removed_value, out_count}))

  // Requests are handled one at a time.
  `CLE_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

  // An empty list reports nothing found or removed and a zero count.
  `CLE_ASSERT_IMP(a_empty, clk, rst_n, out_valid && (out_status == ST_EMPTY), !out_found && (out_removed_value == '0) && (out_count == '0))

  // A missing key changes nothing and removes nothing.
  `CLE_ASSERT_IMP(a_notfound, clk, rst_n, out_valid && (out_status == ST_NOTFOUND), !out_found && (out_removed_value == '0))

  // A refused insert only happens at full capacity.
  `CLE_ASSERT_IMP(a_full, clk, rst_n, out_valid && (out_status == ST_FULL), out_count == CAP_C)

endmodule

bind circular_list_engine cle_checker #(
  .CAPACITY (CAPACITY)
) u_cle_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_found         (out_ch.found),
  .out_removed_value (out_ch.removed_value),
  .out_count         (out_ch.count)
);

`default_nettype wire

>>> tb/circular_list_engine_tb.sv
// Self-checking testbench for the circular list engine: random request words against a list mirror.
`timescale 1ns / 1ps

import cle_pkg::*;

typedef struct packed {
  status_t            status;
  logic               found;
  logic signed [31:0] removed;
  logic [4:0]         count;
} reply_t;

// Mirrors the list contents and queues the reply word each request should produce.
class list_mirror;
  logic signed [31:0] values[$];
  reply_t             owed_replies[$];
  int                 replies_seen;
  int                 mismatches;

  function void note_request(logic [2:0] kind, logic signed [31:0] data,
                             logic signed [31:0] key);
    reply_t r;
    int     hit;
    r   = '{ST_OK, 1'b0, 32'sd0, 5'd0};
    hit = -1;
    for (int i = 0; i < values.size(); i++) begin
      if (hit < 0 && values[i] == key) hit = i;
    end
    case (kind)
      K_INS_HEAD, K_INS_TAIL: begin
        if (values.size() >= CLE_CAPACITY) r.status = ST_FULL;
        else if (kind == K_INS_HEAD) values.push_front(data);
        else values.push_back(data);
      end
      K_INS_AFTER: begin
        if (values.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          // A matching key on a full list still reports found.
          r.found = 1'b1;
          if (values.size() >= CLE_CAPACITY) r.status = ST_FULL;
          else values.insert(hit + 1, data);
        end
      end
      K_DEL_HEAD, K_DEL_TAIL: begin
        if (values.size() == 0) r.status = ST_EMPTY;
        else if (kind == K_DEL_HEAD) r.removed = values.pop_front();
        else r.removed = values.pop_back();
      end
      K_DEL_KEY, K_SEARCH: begin
        if (values.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found = 1'b1;
          if (kind == K_DEL_KEY) begin
            r.removed = values[hit];
            values.delete(hit);
          end
        end
      end
      default: ;
    endcase
    r.count = 5'(values.size());
    owed_replies.push_back(r);
  endfunction

  function void check_reply(logic [1:0] status, logic found, logic signed [31:0] removed,
                            logic [4:0] count);
    reply_t e;
    replies_seen++;
    if (owed_replies.size() == 0) begin
      $display("%0t: result word with no request pending, status %0d count %0d",
               $time, status, count);
      mismatches++;
      return;
    end
    e = owed_replies.pop_front();
    if (status !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, status);
      mismatches++;
    end
    if (found !== e.found) begin
      $display("%0t: found expected %0d actual %0d", $time, e.found, found);
      mismatches++;
    end
    if (removed !== e.removed) begin
      $display("%0t: removed_value expected %0d actual %0d", $time, e.removed, removed);
      mismatches++;
    end
    if (count !== e.count) begin
      $display("%0t: count expected %0d actual %0d", $time, e.count, count);
      mismatches++;
    end
  endfunction
endclass

module circular_list_engine_tb;

  // The three-bit kind field has one code the block does not define.
  localparam logic [2:0] K_UNUSED = 3'd7;
  localparam int LATENCY = CLE_CAPACITY + 3;
  localparam int RANDOM_WORDS = 850;
  localparam int CYCLE_LIMIT = 400000;
  // After this many replies the receiver holds off once for a long stretch.
  localparam int HOLD_AFTER = 120;
  localparam int HOLD_CYCLES = 250;

  logic clk;
  logic rst_n;
  int   cycles;

  cle_in_if in_ch ();
  cle_out_if #(.CNT_W($clog2(CLE_CAPACITY + 1))) out_ch ();

  list_mirror mirror;

  circular_list_engine dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Every accepted result word is checked against the oldest owed reply. The
  // outputs are read at the rising edge, before the block updates them.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      mirror.check_reply(out_ch.status, out_ch.found, out_ch.removed_value, out_ch.count);
    end
  end

  // The receiver runs on a pattern of its own: windows of steady readiness,
  // windows of random stalls, and one long hold-off after a while. During the
  // hold-off the sender keeps offering words, so the block must fill up and
  // push back on its input.
  initial begin
    bit held;
    int mode;
    int span;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && mirror.replies_seen >= HOLD_AFTER) begin
        held = 1'b1;
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Offers one request word and holds it until the block accepts it. It is
  // entered at a falling edge and returns at the falling edge after acceptance.
  task automatic send_word(logic [2:0] kind, logic signed [31:0] data,
                           logic signed [31:0] key);
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.data  <= data;
    in_ch.key   <= key;
    do @(posedge clk); while (!in_ch.ready);
    mirror.note_request(kind, data, key);
    @(negedge clk);
  endtask

  // Lowers valid and waits until every owed reply has come back.
  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (mirror.owed_replies.size() != 0) @(negedge clk);
  endtask

  // Values lean toward a small pool so that duplicates and key hits are common.
  function automatic logic signed [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $signed($urandom_range(0, 7)) - 4;
    if (roll < 50) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // Most keys name a value that is in the list, the rest are likely misses.
  function automatic logic signed [31:0] pick_key();
    if (mirror.values.size() != 0 && $urandom_range(0, 99) < 70) begin
      return mirror.values[$urandom_range(0, mirror.values.size() - 1)];
    end
    return pick_value();
  endfunction

  // While growing, inserts dominate; while shrinking, deletes do. This walks
  // the list between empty and full over and over.
  function automatic logic [2:0] pick_kind(bit growing);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return K_UNUSED;
    if (roll < 14) return K_SEARCH;
    if (growing ? (roll < 70) : (roll < 32)) begin
      case ($urandom_range(0, 2))
        0: return K_INS_HEAD;
        1: return K_INS_TAIL;
        default: return K_INS_AFTER;
      endcase
    end
    case ($urandom_range(0, 2))
      0: return K_DEL_HEAD;
      1: return K_DEL_TAIL;
      default: return K_DEL_KEY;
    endcase
  endfunction

  initial begin
    bit         growing;
    int         burst_left;
    int         gap;
    logic [2:0] kind;
    mirror = new;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = K_INS_HEAD;
    in_ch.data = 32'sd0;
    in_ch.key = 32'sd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every request that needs an entry, plus the undefined kind, on the empty list.
    send_word(K_INS_AFTER, 32'sd1, 32'sd0);
    send_word(K_DEL_HEAD, 32'sd0, 32'sd0);
    send_word(K_DEL_TAIL, 32'sd0, 32'sd0);
    send_word(K_DEL_KEY, 32'sd0, 32'sd0);
    send_word(K_SEARCH, 32'sd0, 32'sd0);
    send_word(K_UNUSED, 32'sd5, 32'sd5);

    // Fill the list with the extremes and a duplicate pair, so that a later
    // insert after the duplicated value must land behind its first copy.
    send_word(K_INS_TAIL, 32'sh8000_0000, 32'sd0);
    send_word(K_INS_HEAD, 32'sh7fff_ffff, 32'sd0);
    send_word(K_INS_AFTER, 32'sd0, 32'sh8000_0000);
    send_word(K_INS_TAIL, 32'sd5, 32'sd0);
    send_word(K_INS_TAIL, 32'sd5, 32'sd0);
    send_word(K_INS_AFTER, 32'sd7, 32'sd5);
    for (int i = 0; i < CLE_CAPACITY - 6; i++) begin
      send_word(i[0] ? K_INS_HEAD : K_INS_TAIL, $urandom, 32'sd0);
    end

    // The list is full now: every insert is refused, a key hit still reports found.
    send_word(K_INS_HEAD, 32'sd9, 32'sd0);
    send_word(K_INS_TAIL, 32'sd9, 32'sd0);
    send_word(K_INS_AFTER, 32'sd9, 32'sd5);
    send_word(K_INS_AFTER, 32'sd9, 32'sd12345);

    // The sender pauses until every reply is in.
    drain_replies();

    growing = 1'b0;
    burst_left = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) begin
        drain_replies();
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      if (mirror.values.size() >= CLE_CAPACITY) growing = 1'b0;
      else if (mirror.values.size() == 0) growing = 1'b1;
      else if ($urandom_range(0, 99) < 3) growing = !growing;
      kind = pick_kind(growing);
      send_word(kind, pick_value(), pick_key());
    end

    drain_replies();
    // The run goes on so that any stray result word is caught.
    repeat (LATENCY + 8) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
